// File: hdl/ifd_pkg.sv
package ifd_pkg;

	// word and field widths
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 15;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LEN_W-1:0]    len_t;

	// framing bytes
	localparam byte_t FLAG_BYTE = 8'h7E;
	localparam byte_t ESC_BYTE  = 8'h7D;
	localparam byte_t ESC_MASK  = 8'h20;
	localparam byte_t ADDR_A    = 8'h01;
	localparam byte_t ADDR_B    = 8'h03;

	// largest payload that is passed on
	localparam len_t MAX_PAYLOAD = 15'd16384;

	// end-of-frame status codes
	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_BAD_BCC2 = 2'd1;
	localparam status_t STAT_OVERFLOW = 2'd2;

endpackage

// File: hdl/ifd_if.sv
// line byte channel
interface ifd_in_if;
	import ifd_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// payload and end-of-frame channel
interface ifd_out_if;
	import ifd_pkg::*;
	logic    valid;
	logic    ready;
	byte_t   payload_byte;
	logic    frame_end;
	status_t status;
	len_t    payload_length;

	modport source (output valid, output payload_byte, output frame_end, output status,
		output payload_length, input ready);
	modport sink (input valid, input payload_byte, input frame_end, input status,
		input payload_length, output ready);
endinterface

// File: hdl/i_frame_deframer_with_destuffing.sv
// A line word is captured in the input stage (byte_s1), decoded against the frame state,
//   and its result is loaded into the output register, held there until taken.
// Takes one line word per cycle while the output register is empty or being taken.
// Reset: arst_n clears the frame state, the input and output valid flags and seq_q (0)
//   at once; in_ch.ready is already high while reset is held.
module i_frame_deframer_with_destuffing
	import ifd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	ifd_in_if.sink           in_ch,
	ifd_out_if.source        out_ch
);

	localparam logic [2:0] ST_HUNT = 3'd0;
	localparam logic [2:0] ST_FLAG = 3'd1;
	localparam logic [2:0] ST_ADDR = 3'd2;
	localparam logic [2:0] ST_CTRL = 3'd3;
	localparam logic [2:0] ST_DATA = 3'd4;

	logic       seq_q;

	// input stage
	logic       valid_s1;
	byte_t      byte_s1;

	// frame state
	logic [2:0] state_q, state_n;
	logic       esc_q, esc_n;
	byte_t      addr_q, addr_n;
	byte_t      ctrl_q, ctrl_n;
	byte_t      held_q, held_n;
	logic       held_valid_q, held_valid_n;
	byte_t      xor_q, xor_n;
	len_t       count_q, count_n;
	logic       ovf_q, ovf_n;

	// result of the current word
	logic       res_valid;
	byte_t      res_byte;
	logic       res_end;
	status_t    res_status;
	len_t       res_len;
	byte_t      data_byte;

	// output register
	logic       out_valid_q;
	byte_t      out_byte_q;
	logic       out_end_q;
	status_t    out_status_q;
	len_t       out_len_q;

	logic       out_free;
	logic       proc;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign proc        = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || proc;

	// hold the sequence register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= 1'b0;
		end else if (cfg_we) begin
			seq_q <= cfg_wdata;
		end
	end

	// capture the line word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	// decode one word against the frame state
	always_comb begin
		state_n      = state_q;
		esc_n        = esc_q;
		addr_n       = addr_q;
		ctrl_n       = ctrl_q;
		held_n       = held_q;
		held_valid_n = held_valid_q;
		xor_n        = xor_q;
		count_n      = count_q;
		ovf_n        = ovf_q;
		res_valid    = 1'b0;
		res_byte     = '0;
		res_end      = 1'b0;
		res_status   = STAT_OK;
		res_len      = '0;
		data_byte    = esc_q ? (byte_s1 ^ ESC_MASK) : byte_s1;

		case (state_q)
			ST_FLAG: begin
				if (byte_s1 == ADDR_A || byte_s1 == ADDR_B) begin
					addr_n  = byte_s1;
					state_n = ST_ADDR;
				end else if (byte_s1 != FLAG_BYTE) begin
					state_n = ST_HUNT;
				end
			end
			ST_ADDR: begin
				if (byte_s1 == {{(BYTE_W-1){1'b0}}, seq_q}) begin
					ctrl_n  = byte_s1;
					state_n = ST_CTRL;
				end else begin
					state_n = (byte_s1 == FLAG_BYTE) ? ST_FLAG : ST_HUNT;
				end
			end
			ST_CTRL: begin
				if (byte_s1 == (addr_q ^ ctrl_q)) begin
					esc_n        = 1'b0;
					held_n       = '0;
					held_valid_n = 1'b0;
					xor_n        = '0;
					count_n      = '0;
					ovf_n        = 1'b0;
					state_n      = ST_DATA;
				end else begin
					state_n = (byte_s1 == FLAG_BYTE) ? ST_FLAG : ST_HUNT;
				end
			end
			ST_DATA: begin
				if (byte_s1 == FLAG_BYTE) begin
					// closing flag: report unless an escape aborts the frame
					if (!esc_q) begin
						res_valid = 1'b1;
						res_end   = 1'b1;
						res_len   = count_q;
						if (ovf_q) begin
							res_status = STAT_OVERFLOW;
						end else if (!held_valid_q || held_q != xor_q) begin
							res_status = STAT_BAD_BCC2;
						end else begin
							res_status = STAT_OK;
						end
					end
					esc_n        = 1'b0;
					held_n       = '0;
					held_valid_n = 1'b0;
					xor_n        = '0;
					count_n      = '0;
					ovf_n        = 1'b0;
					state_n      = ST_FLAG;
				end else if (!esc_q && byte_s1 == ESC_BYTE) begin
					esc_n = 1'b1;
				end else begin
					// release the held word (or flag overflow at the bound), hold the new one
					esc_n = 1'b0;
					if (held_valid_q) begin
						if (count_q < MAX_PAYLOAD) begin
							res_valid = 1'b1;
							res_byte  = held_q;
							xor_n     = xor_q ^ held_q;
							count_n   = count_q + 15'd1;
						end else begin
							ovf_n = 1'b1;
						end
					end
					held_n       = data_byte;
					held_valid_n = 1'b1;
				end
			end
			default: begin
				state_n = (byte_s1 == FLAG_BYTE) ? ST_FLAG : ST_HUNT;
			end
		endcase
	end

	// advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HUNT;
			esc_q        <= 1'b0;
			addr_q       <= '0;
			ctrl_q       <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			xor_q        <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
		end else if (proc) begin
			state_q      <= state_n;
			esc_q        <= esc_n;
			addr_q       <= addr_n;
			ctrl_q       <= ctrl_n;
			held_q       <= held_n;
			held_valid_q <= held_valid_n;
			xor_q        <= xor_n;
			count_q      <= count_n;
			ovf_q        <= ovf_n;
		end
	end

	// load or drain the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= res_valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			out_byte_q   <= res_byte;
			out_end_q    <= res_end;
			out_status_q <= res_status;
			out_len_q    <= res_len;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.payload_byte   = out_byte_q;
	assign out_ch.frame_end      = out_end_q;
	assign out_ch.status         = out_status_q;
	assign out_ch.payload_length = out_len_q;

`ifndef ASSERT_OFF
	// payload words carry no status and no length
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_end_q |-> out_status_q == STAT_OK && out_len_q == '0)
		else $error("payload word with status or length");

	// count never passes the bound, and overflow only at the bound
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == MAX_PAYLOAD)
		else $error("overflow set below the payload bound");

	// an escape is pending only inside a frame
	a_esc_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> state_q == ST_DATA)
		else $error("escape pending outside a frame");

	// a waiting result holds while the sink stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_end_q)
			&& $stable(out_byte_q) && $stable(out_len_q))
		else $error("stalled result changed");
`endif

endmodule
